[design/nwa_pkg.sv]
// Shared constants, types and helper functions of the NFA word acceptor.
package nwa_pkg;

  // Automaton size
  localparam int NUM_STATES  = 32;
  localparam int NUM_SYMBOLS = 256;

  // Fixed field widths of the item and of the registers
  localparam int STATE_W = 5;
  localparam int SYM_W   = 8;
  localparam int FINAL_W = 32;

  // Table geometry: one row of NUM_STATES bits per (state, symbol) pair
  localparam int IDX_W       = $clog2(NUM_STATES);
  localparam int SIDX_W      = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W      = IDX_W + SIDX_W;
  localparam int TABLE_DEPTH = NUM_STATES << SIDX_W;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_END   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_FEED
  } st_e;

  typedef enum logic {
    REG_INITIAL = 1'b0,
    REG_FINAL   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [STATE_W-1:0] initial_state;
    logic [FINAL_W-1:0] final_mask;
  } cfg_t;

  // One-hot set for a state index; empty when the index names no state
  function automatic logic [NUM_STATES-1:0] state_bit(input logic [STATE_W-1:0] s);
    logic [NUM_STATES-1:0] set_v;
    set_v = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      set_v[i] = (int'(s) == i);
    end
    return set_v;
  endfunction

  // Final states restricted to the automaton's size
  function automatic logic [NUM_STATES-1:0] final_set(input logic [FINAL_W-1:0] mask);
    return NUM_STATES'(mask);
  endfunction

  // Index of the lowest set bit (priority encoder)
  function automatic logic [IDX_W-1:0] lowest_idx(input logic [NUM_STATES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

[design/nwa_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
module nwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/nwa_apb.sv]
// APB-style configuration registers: initial state and final-state mask.
module nwa_apb (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nwa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nwa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nwa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output nwa_pkg::cfg_t                  cfg_o
);

  logic [nwa_pkg::STATE_W-1:0] initial_q, initial_d;
  logic [nwa_pkg::FINAL_W-1:0] final_q, final_d;
  nwa_pkg::reg_e               reg_sel;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = nwa_pkg::reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write decode
  always_comb begin
    initial_d = initial_q;
    final_d   = final_q;
    if (wr_en) begin
      unique case (reg_sel)
        nwa_pkg::REG_INITIAL: initial_d = pwdata[nwa_pkg::STATE_W-1:0];
        nwa_pkg::REG_FINAL:   final_d   = pwdata[nwa_pkg::FINAL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_q <= '0;
      final_q   <= '0;
    end else begin
      initial_q <= initial_d;
      final_q   <= final_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      nwa_pkg::REG_INITIAL: prdata = nwa_pkg::CFG_DATA_W'(initial_q);
      nwa_pkg::REG_FINAL:   prdata = nwa_pkg::CFG_DATA_W'(final_q);
    endcase
  end

  assign cfg_o.initial_state = initial_q;
  assign cfg_o.final_mask    = final_q;

endmodule

[design/nwa_engine.sv]
// Command sequencer around the transition table: clear, add, feed and end of word.
module nwa_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  nwa_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic [nwa_pkg::STATE_W-1:0] from_state_i,
  input  logic [nwa_pkg::SYM_W-1:0]   symbol_i,
  input  logic [nwa_pkg::STATE_W-1:0] to_state_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        accepted_o
);

  localparam int NS = nwa_pkg::NUM_STATES;

  nwa_pkg::st_e                state_q, state_d;
  nwa_pkg::cmd_e               cmd;
  logic                        in_acc;
  logic                        add_ok;
  logic                        sym_ok;
  logic                        feed_done;
  logic                        clr_last;
  logic [NS-1:0]               cur_set;

  logic [nwa_pkg::ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic [nwa_pkg::IDX_W-1:0]   from_q, from_d;
  logic [nwa_pkg::SIDX_W-1:0]  sym_q, sym_d;
  logic [nwa_pkg::STATE_W-1:0] to_q, to_d;
  logic [NS-1:0]               pending_q, pending_d;
  logic [NS-1:0]               acc_q, acc_d;
  logic                        rd_pend_q, rd_pend_d;
  logic [NS-1:0]               active_q, active_d;
  logic                        word_start_q, word_start_d;
  logic                        out_valid_q, out_valid_d;
  logic                        accepted_q, accepted_d;

  logic                        ram_we;
  logic [nwa_pkg::ADDR_W-1:0]  ram_waddr;
  logic [NS-1:0]               ram_wdata;
  logic [nwa_pkg::ADDR_W-1:0]  ram_raddr;
  logic [NS-1:0]               ram_rdata;

  // Transition table: one row per (state, symbol)
  nwa_ram #(
    .WIDTH (NS),
    .DEPTH (nwa_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Decode of the incoming item
  assign cmd       = nwa_pkg::cmd_e'(command_i);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign sym_ok    = int'(symbol_i) < nwa_pkg::NUM_SYMBOLS;
  assign add_ok    = sym_ok && (int'(from_state_i) < NS) && (int'(to_state_i) < NS);
  assign cur_set   = word_start_q ? nwa_pkg::state_bit(cfg_i.initial_state) : active_q;
  assign feed_done = (pending_q == '0) && !rd_pend_q;
  assign clr_last  = clr_addr_q == nwa_pkg::ADDR_W'(nwa_pkg::TABLE_DEPTH - 1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nwa_pkg::ST_CLEAR: begin
        if (clr_last) state_d = nwa_pkg::ST_IDLE;
      end
      nwa_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            nwa_pkg::CMD_ADD:   state_d = add_ok ? nwa_pkg::ST_ADD_WR : nwa_pkg::ST_IDLE;
            nwa_pkg::CMD_FEED:  state_d = nwa_pkg::ST_FEED;
            nwa_pkg::CMD_END:   state_d = nwa_pkg::ST_IDLE;
            nwa_pkg::CMD_CLEAR: state_d = nwa_pkg::ST_CLEAR;
          endcase
        end
      end
      nwa_pkg::ST_ADD_WR: state_d = nwa_pkg::ST_IDLE;
      nwa_pkg::ST_FEED: begin
        if (feed_done) state_d = nwa_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory controls and input stall
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = clr_addr_q;
    ram_wdata  = '0;
    ram_raddr  = {nwa_pkg::IDX_W'(from_state_i), nwa_pkg::SIDX_W'(symbol_i)};
    in_stall_o = 1'b1;
    unique case (state_q)
      nwa_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      nwa_pkg::ST_IDLE: begin
        // an end of word waits only while the previous result is still held
        in_stall_o = (cmd == nwa_pkg::CMD_END) && out_valid_q && out_stall_i;
      end
      nwa_pkg::ST_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {from_q, sym_q};
        ram_wdata = ram_rdata | nwa_pkg::state_bit(to_q);
      end
      nwa_pkg::ST_FEED: begin
        ram_raddr = {nwa_pkg::lowest_idx(pending_q), sym_q};
      end
    endcase
  end

  // Datapath: item capture, active-set scan and result
  always_comb begin
    clr_addr_d   = clr_addr_q;
    from_d       = from_q;
    sym_d        = sym_q;
    to_d         = to_q;
    pending_d    = pending_q;
    acc_d        = acc_q;
    rd_pend_d    = rd_pend_q;
    active_d     = active_q;
    word_start_d = word_start_q;
    accepted_d   = accepted_q;
    out_valid_d  = out_valid_q && out_stall_i;

    unique case (state_q)
      nwa_pkg::ST_CLEAR: begin
        clr_addr_d = clr_addr_q + nwa_pkg::ADDR_W'(1);
      end
      nwa_pkg::ST_IDLE: begin
        if (in_acc) begin
          from_d = nwa_pkg::IDX_W'(from_state_i);
          sym_d  = nwa_pkg::SIDX_W'(symbol_i);
          to_d   = to_state_i;
          unique case (cmd)
            nwa_pkg::CMD_ADD: ;
            nwa_pkg::CMD_FEED: begin
              pending_d = sym_ok ? cur_set : '0;
              acc_d     = '0;
              rd_pend_d = 1'b0;
            end
            nwa_pkg::CMD_END: begin
              accepted_d   = |(cur_set & nwa_pkg::final_set(cfg_i.final_mask));
              out_valid_d  = 1'b1;
              word_start_d = 1'b1;
            end
            nwa_pkg::CMD_CLEAR: clr_addr_d = '0;
          endcase
        end
      end
      nwa_pkg::ST_ADD_WR: ;
      nwa_pkg::ST_FEED: begin
        // one row read per active state, merged from the registered read data
        pending_d = pending_q & (pending_q - NS'(1));
        rd_pend_d = |pending_q;
        if (rd_pend_q) acc_d = acc_q | ram_rdata;
        if (feed_done) begin
          active_d     = acc_q;
          word_start_d = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nwa_pkg::ST_CLEAR;
      clr_addr_q   <= '0;
      pending_q    <= '0;
      acc_q        <= '0;
      rd_pend_q    <= 1'b0;
      active_q     <= '0;
      word_start_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      pending_q    <= pending_d;
      acc_q        <= acc_d;
      rd_pend_q    <= rd_pend_d;
      active_q     <= active_d;
      word_start_q <= word_start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Item payload and result
  always_ff @(posedge clk_i) begin
    from_q     <= from_d;
    sym_q      <= sym_d;
    to_q       <= to_d;
    accepted_q <= accepted_d;
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

  // Checks
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == nwa_pkg::ST_IDLE)
    else $error("item taken while busy");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd == nwa_pkg::CMD_END |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while held");

  a_read_in_feed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> state_q == nwa_pkg::ST_FEED && !ram_we)
    else $error("row read outstanding outside feed");

  a_feed_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nwa_pkg::ST_FEED && feed_done
      |=> state_q == nwa_pkg::ST_IDLE && !word_start_q && active_q == $past(acc_q))
    else $error("feed did not commit the new set");

  a_clear_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nwa_pkg::ST_CLEAR && clr_last |=> state_q == nwa_pkg::ST_IDLE)
    else $error("clearing pass overran");

endmodule

[design/nfa_word_acceptor.sv]
// Top level of the NFA word acceptor: configuration registers and command engine.
//
// Simulates a nondeterministic automaton of NUM_STATES states over byte symbols.
// The transition table lives in one RAM of NUM_STATES*256 rows with one write port
// and one read port; each row holds the next-state set for one (state, symbol)
// pair. After reset, and after every clear-table item, the block sweeps the RAM
// one row per cycle with the input stalled; configuration writes are taken as
// usual. Item timing is set by the RAM's single read port: an add-transition item
// reads its row, then writes it back; an end-of-word item uses no table row; a
// feed-symbol item reads one table row per currently active state, then merges the
// last row and commits the new set. End of word returns one result (accepted); it
// is held in an output register, so the next item can be taken while the result
// waits, though a further end of word waits until it is taken. Initial state and
// final mask are read live, so change them only while the block is idle.
module nfa_word_acceptor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nwa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [nwa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [nwa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic [nwa_pkg::STATE_W-1:0]    from_state_i,
  input  logic [nwa_pkg::SYM_W-1:0]      symbol_i,
  input  logic [nwa_pkg::STATE_W-1:0]    to_state_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o
);

  nwa_pkg::cfg_t cfg;

  nwa_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nwa_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .from_state_i (from_state_i),
    .symbol_i     (symbol_i),
    .to_state_i   (to_state_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o)
  );

endmodule

[tb/nfa_word_acceptor_test.sv]
// Self-checking testbench for the NFA word acceptor against a state-set predictor.
`timescale 1ns / 100ps

module nfa_word_acceptor_test;
  import nwa_pkg::*;

  localparam int          CYCLE_LIMIT     = 500000;
  localparam int          SETTLE_CYCLES   = 48;   // longer than the slowest feed
  localparam int          TAIL_CYCLES     = 48;
  localparam int          WORDS_PER_PHASE = 12;
  localparam int          RANDOM_PHASES   = 6;
  localparam logic [SYM_W-1:0] FAN_SYM    = 8'h55;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Block ports
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            command_i    = '0;
  logic [STATE_W-1:0]    from_state_i = '0;
  logic [SYM_W-1:0]      symbol_i     = '0;
  logic [STATE_W-1:0]    to_state_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  accepted_o;

  nfa_word_acceptor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .from_state_i (from_state_i),
    .symbol_i     (symbol_i),
    .to_state_i   (to_state_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o)
  );

  // Shadow automaton
  logic [NUM_STATES-1:0] next_rows [TABLE_DEPTH];
  logic [NUM_STATES-1:0] live_states;
  bit                    fresh_word;
  logic [STATE_W-1:0]    start_state;
  logic [FINAL_W-1:0]    accept_mask;
  logic                  expected_verdicts [$];

  // Run bookkeeping
  int unsigned cycle_count    = 0;
  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned verdicts_seen  = 0;
  bit          idle_draws     = 1'b1;
  int unsigned rx_wait        = 0;
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;

  // Set holding one state, empty for an index beyond the automaton
  function automatic logic [NUM_STATES-1:0] onehot_state(input logic [STATE_W-1:0] s);
    if (int'(s) >= NUM_STATES) return '0;
    return NUM_STATES'(1) << s;
  endfunction

  function automatic logic [STATE_W-1:0] any_state();
    return STATE_W'($urandom_range(0, (1 << STATE_W) - 1));
  endfunction

  function automatic logic [SYM_W-1:0] any_symbol();
    return SYM_W'($urandom_range(0, (1 << SYM_W) - 1));
  endfunction

  // Apply one accepted item to the shadow automaton
  function automatic void advance_automaton(input cmd_e cmd, input logic [STATE_W-1:0] src,
                                            input logic [SYM_W-1:0] sym,
                                            input logic [STATE_W-1:0] dst);
    logic [NUM_STATES-1:0] cur;
    logic [NUM_STATES-1:0] nxt;
    cur = fresh_word ? onehot_state(start_state) : live_states;
    case (cmd)
      CMD_ADD: begin
        if (int'(src) < NUM_STATES && int'(dst) < NUM_STATES && int'(sym) < NUM_SYMBOLS)
          next_rows[int'(src) * NUM_SYMBOLS + int'(sym)] |= onehot_state(dst);
      end
      CMD_FEED: begin
        nxt = '0;
        if (int'(sym) < NUM_SYMBOLS) begin
          for (int s = 0; s < NUM_STATES; s++) begin
            if (cur[s]) nxt |= next_rows[s * NUM_SYMBOLS + int'(sym)];
          end
        end
        live_states = nxt;
        fresh_word  = 1'b0;
      end
      CMD_END: begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 |(cur & NUM_STATES'(accept_mask)));
        fresh_word  = 1'b1;
        live_states = onehot_state(start_state);
      end
      default: begin
        // clear leaves the active set alone
        for (int i = 0; i < TABLE_DEPTH; i++) next_rows[i] = '0;
      end
    endcase
  endfunction

  // Offer one item, after a random gap when idle_draws is set; returns at the edge that takes it
  task automatic send_item(input cmd_e cmd, input logic [STATE_W-1:0] src,
                           input logic [SYM_W-1:0] sym, input logic [STATE_W-1:0] dst);
    int unsigned gap;
    gap = idle_draws ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    from_state_i <= src;
    symbol_i     <= sym;
    to_state_i   <= dst;
    do @(posedge clk_i); while (in_stall_o);
    advance_automaton(cmd, src, sym, dst);
    items_sent++;
  endtask

  // Drop valid and wait for every outstanding verdict
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Idle the block fully, so a register write cannot overtake a feed
  task automatic quiesce();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle then access cycle
  task automatic write_register(input reg_e which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(which) * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (which == REG_INITIAL) start_state = value[STATE_W-1:0];
    else accept_mask = value[FINAL_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random stall after each taken result while idle_draws is set, plus long holds on request
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each taken result with the oldest predicted verdict
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $error("accepted: no result expected, actual %0b", accepted_o);
        fail_count++;
      end else begin
        if (accepted_o !== expected_verdicts[0]) begin
          $error("accepted: expected %0b, actual %0b", expected_verdicts[0], accepted_o);
          fail_count++;
        end
        void'(expected_verdicts.pop_front());
      end
      verdicts_seen++;
      rx_wait = idle_draws ? $urandom_range(0, 4) : 0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Empty words: verdict comes from the initial state alone
  task automatic test_empty_word();
    send_item(CMD_END, '0, '0, '0);
    quiesce();
    write_register(REG_FINAL, 32'h0000_0001);
    send_item(CMD_END, '1, '1, '1);
    quiesce();
    write_register(REG_INITIAL, 32'd31);
    write_register(REG_FINAL, 32'h8000_0000);
    send_item(CMD_END, '0, '1, '0);
  endtask

  // Transitions, duplicates, nondeterministic branching and a dying word
  task automatic test_add_and_feed();
    quiesce();
    write_register(REG_INITIAL, 32'd0);
    write_register(REG_FINAL, 32'h8000_0001);
    send_item(CMD_ADD, 5'd0, 8'h00, 5'd31);
    send_item(CMD_ADD, 5'd31, 8'hFF, 5'd0);
    send_item(CMD_ADD, 5'd0, 8'h00, 5'd31);
    send_item(CMD_ADD, 5'd0, 8'h00, 5'd1);
    send_item(CMD_ADD, 5'd31, 8'hFF, 5'd31);
    send_item(CMD_FEED, '0, 8'h00, '0);
    send_item(CMD_FEED, '1, 8'hFF, '1);
    send_item(CMD_END, '0, '0, '0);
    send_item(CMD_FEED, '0, 8'h00, '0);
    send_item(CMD_FEED, '0, 8'h00, '0);
    send_item(CMD_END, '0, '0, '0);
  endtask

  // Clear empties the table but keeps the active set
  task automatic test_clear_table();
    send_item(CMD_FEED, '0, 8'h00, '0);
    send_item(CMD_CLEAR, '1, '1, '1);
    send_item(CMD_END, '0, '0, '0);
    send_item(CMD_FEED, '0, 8'h00, '0);
    send_item(CMD_END, '0, '0, '0);
  endtask

  // One setting: small automaton over a few symbols, then words mostly over them
  task automatic run_word_phase(input int phase_no);
    logic [SYM_W-1:0]   alphabet [4];
    logic [STATE_W-1:0] pool [8];
    logic [FINAL_W-1:0] mask;
    logic [SYM_W-1:0]   sym;
    int unsigned        word_len;
    for (int i = 0; i < 4; i++) alphabet[i] = any_symbol();
    for (int i = 0; i < 8; i++) pool[i] = any_state();
    if (phase_no == 0) pool[0] = 5'd31;
    if (phase_no == 1) pool[0] = 5'd0;
    mask = $urandom & $urandom & $urandom;
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 1) == 1) mask |= FINAL_W'(1) << pool[i];
    end
    if (phase_no == 0) mask = '1;
    if (phase_no == 1) mask = '0;
    idle_draws = (phase_no != 3);
    quiesce();
    write_register(REG_INITIAL, CFG_DATA_W'(pool[0]));
    write_register(REG_FINAL, mask);
    if (phase_no == 2 || phase_no == 4) send_item(CMD_CLEAR, any_state(), any_symbol(), any_state());
    // build the automaton
    for (int i = 0; i < 30; i++) begin
      send_item(CMD_ADD, pool[$urandom_range(0, 7)], alphabet[$urandom_range(0, 3)],
                pool[$urandom_range(0, 7)]);
    end
    // words, with stray items between them now and then
    for (int w = 0; w < WORDS_PER_PHASE; w++) begin
      word_len = $urandom_range(0, 6);
      for (int k = 0; k < word_len; k++) begin
        sym = ($urandom_range(0, 9) == 0) ? any_symbol() : alphabet[$urandom_range(0, 3)];
        send_item(CMD_FEED, any_state(), sym, any_state());
      end
      send_item(CMD_END, any_state(), any_symbol(), any_state());
      if ($urandom_range(0, 4) == 0)
        send_item(cmd_e'($urandom_range(0, 2)), any_state(), any_symbol(), any_state());
      if (w == WORDS_PER_PHASE / 2) wait_results_drained();
    end
    idle_draws = 1'b1;
  endtask

  task automatic test_random_words();
    for (int p = 0; p < RANDOM_PHASES; p++) run_word_phase(p);
  endtask

  // Every state active at once while the result side holds off for a long stretch
  task automatic test_output_backpressure();
    int unsigned word_len;
    quiesce();
    write_register(REG_INITIAL, 32'd0);
    write_register(REG_FINAL, $urandom);
    for (int s = 0; s < NUM_STATES; s++) send_item(CMD_ADD, 5'd0, FAN_SYM, STATE_W'(s));
    hold_request = 400;
    for (int w = 0; w < 10; w++) begin
      word_len = $urandom_range(0, 3);
      for (int k = 0; k < word_len; k++) begin
        send_item(CMD_FEED, any_state(), ($urandom_range(0, 5) == 0) ? FAN_SYM + 8'd1 : FAN_SYM,
                  any_state());
      end
      send_item(CMD_END, any_state(), any_symbol(), any_state());
    end
    wait_results_drained();
  endtask

  // Sequence
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) next_rows[i] = '0;
    start_state = '0;
    accept_mask = '0;
    fresh_word  = 1'b1;
    live_states = onehot_state('0);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_word();
    test_add_and_feed();
    test_clear_table();
    test_random_words();
    test_output_backpressure();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_verdicts.size() != 0) begin
      $error("accepted: %0d expected results never arrived", expected_verdicts.size());
      fail_count++;
    end
    $display("Sent %0d items: adds, feeds, word ends and clears over six settings,",
             items_sent);
    $display("random idling and a long output hold; %0d verdicts compared, %0d failures.",
             verdicts_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
